[hdl/stereo_gain_onepole_biquad_stage_defines.svh]
// Assertion macros used by the stereo effect stage checker.
`ifndef STEREO_GAIN_ONEPOLE_BIQUAD_STAGE_DEFINES_SVH
`define STEREO_GAIN_ONEPOLE_BIQUAD_STAGE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SGOB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SGOB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sgob_pkg.sv]
// Shared constants, codes and control types of the stereo effect stage.
`default_nettype none

package sgob_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;
  localparam int STATE_BITS      = 48;
  localparam int POLE_GUARD      = 8;
  localparam int BQ_GUARD        = 4;
  localparam int GAIN_INT_BITS   = 8;
  localparam int POLE_INT_BITS   = 2;
  localparam int BQ_INT_BITS     = 5;
  localparam int REG_IDX_BITS    = 3;

  typedef enum logic [1:0] {
    KIND_BYPASS,
    KIND_GAIN,
    KIND_POLE,
    KIND_BIQUAD
  } kind_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_EFFECT_KIND,
    REG_GAIN_FACTOR,
    REG_POLE_COEF,
    REG_COEF_B0,
    REG_COEF_B1,
    REG_COEF_B2,
    REG_COEF_A1,
    REG_COEF_A2
  } reg_idx_t;

  typedef enum logic [2:0] {
    COEF_GAIN,
    COEF_POLE,
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_sel_t;

  typedef enum logic [1:0] {
    OPB_X,
    OPB_YS,
    OPB_DIFF
  } opb_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    BIAS_GAIN,
    BIAS_POLE,
    BIAS_BQ,
    BIAS_BQ_Y
  } bias_sel_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_GAIN_OUT,
    WB_POLE_DIFF,
    WB_POLE_STATE,
    WB_POLE_OUT,
    WB_BQ_Y,
    WB_BQ_YS,
    WB_BQ_Z1,
    WB_BQ_Z2
  } wb_op_t;

  // One step of the sequencer: multiplier issue, accumulator op, writeback.
  typedef struct packed {
    logic      mul_en;
    coef_sel_t coef_sel;
    opb_sel_t  opb_sel;
    acc_op_t   acc_op;
    bias_sel_t bias_sel;
    wb_op_t    wb_op;
    logic      ch;
  } ctrl_t;

endpackage

`default_nettype wire

[hdl/sgob_ifs.sv]
// Request channel interfaces: input frames, result frames, register writes.
`default_nettype none

interface sgob_in_if import sgob_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic                          left_only;

  modport source(output valid, output sample_left, output sample_right,
                 output left_only, input ready);
  modport sink(input valid, input sample_left, input sample_right,
               input left_only, output ready);
endinterface

interface sgob_out_if import sgob_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source(output valid, output out_left, output out_right, input ready);
  modport sink(input valid, input out_left, input out_right, output ready);
endinterface

interface sgob_cfg_if import sgob_pkg::*; #(
  parameter int COEF_BITS = COEF_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [REG_IDX_BITS-1:0] index;
  logic [COEF_BITS-1:0]    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/sgob_cfg.sv]
// Configuration register file with coefficient operand select.
`default_nettype none

module sgob_cfg import sgob_pkg::*; #(
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sgob_cfg_if.sink                    cfg_chan,
  input  coef_sel_t                   coef_sel,
  output kind_t                       kind,
  output logic signed [COEF_BITS-1:0] coef
);

  localparam logic signed [COEF_BITS-1:0] GAIN_ONE =
    COEF_BITS'(1) <<< (COEF_BITS - GAIN_INT_BITS);
  localparam logic signed [COEF_BITS-1:0] BQ_ONE =
    COEF_BITS'(1) <<< (COEF_BITS - BQ_INT_BITS);

  kind_t                       kind_r;
  logic signed [COEF_BITS-1:0] gain_r;
  logic        [COEF_BITS-2:0] pole_r;
  logic signed [COEF_BITS-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic                        wr_en;

  assign cfg_chan.ready = 1'b1;
  assign wr_en          = cfg_chan.valid && cfg_chan.ready;
  assign kind           = kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_BYPASS;
      gain_r <= GAIN_ONE;
      pole_r <= '0;
      b0_r   <= BQ_ONE;
      b1_r   <= '0;
      b2_r   <= '0;
      a1_r   <= '0;
      a2_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx_t'(cfg_chan.index))
        REG_EFFECT_KIND: kind_r <= kind_t'(cfg_chan.data[1:0]);
        REG_GAIN_FACTOR: gain_r <= cfg_chan.data;
        REG_POLE_COEF:   pole_r <= cfg_chan.data[COEF_BITS-2:0];
        REG_COEF_B0:     b0_r   <= cfg_chan.data;
        REG_COEF_B1:     b1_r   <= cfg_chan.data;
        REG_COEF_B2:     b2_r   <= cfg_chan.data;
        REG_COEF_A1:     a1_r   <= cfg_chan.data;
        REG_COEF_A2:     a2_r   <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (coef_sel)
      COEF_GAIN: coef = gain_r;
      COEF_POLE: coef = {1'b0, pole_r};
      COEF_B0:   coef = b0_r;
      COEF_B1:   coef = b1_r;
      COEF_B2:   coef = b2_r;
      COEF_A1:   coef = a1_r;
      COEF_A2:   coef = a2_r;
      default:   coef = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/sgob_mac.sv]
// Shared multiply-accumulate unit: registered product, then accumulator.
`default_nettype none

module sgob_mac import sgob_pkg::*; #(
  parameter int COEF_BITS = COEF_BITS_DEF,
  parameter int OPB_W     = SAMPLE_BITS_DEF + POLE_GUARD + 1,
  parameter int ACC_W     = COEF_BITS_DEF + SAMPLE_BITS_DEF + POLE_GUARD + 3
) (
  input  logic                        clk,
  input  ctrl_t                       ctrl,
  input  logic signed [COEF_BITS-1:0] coef,
  input  logic signed [OPB_W-1:0]     opb,
  output logic signed [ACC_W-1:0]     acc
);

  localparam int PROD_W  = COEF_BITS + OPB_W;
  localparam int GAIN_SH = COEF_BITS - GAIN_INT_BITS;
  localparam int POLE_SH = COEF_BITS - POLE_INT_BITS;
  localparam int BQ_SH   = COEF_BITS - BQ_INT_BITS - BQ_GUARD;

  // Half an output LSB; the biquad output step also folds in half of
  // the guard-bit rounding so the later shift by the guard is a plain floor.
  localparam logic signed [ACC_W-1:0] GAIN_BIAS = ACC_W'(1) <<< (GAIN_SH - 1);
  localparam logic signed [ACC_W-1:0] POLE_BIAS = ACC_W'(1) <<< (POLE_SH - 1);
  localparam logic signed [ACC_W-1:0] BQ_BIAS   = ACC_W'(1) <<< (BQ_SH - 1);
  localparam logic signed [ACC_W-1:0] BQ_Y_BIAS =
    BQ_BIAS + (ACC_W'(1) <<< (BQ_SH + BQ_GUARD - 1));

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  bias;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_nxt = PROD_W'(coef) * PROD_W'(opb);
  assign prod_ext = ACC_W'(prod_r);
  assign acc      = acc_r;

  always_comb begin
    case (ctrl.bias_sel)
      BIAS_GAIN: bias = GAIN_BIAS;
      BIAS_POLE: bias = POLE_BIAS;
      BIAS_BQ:   bias = BQ_BIAS;
      BIAS_BQ_Y: bias = BQ_Y_BIAS;
      default:   bias = '0;
    endcase
  end

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD: acc_nxt = bias + prod_ext;
      ACC_SUB:  acc_nxt = acc_r - prod_ext;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
  end

endmodule

`default_nettype wire

[hdl/sgob_seq.sv]
// Step sequencer: walks each channel through the chosen effect's steps.
`default_nettype none

module sgob_seq import sgob_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  kind_t kind,
  input  logic  left_only,
  input  logic  out_free,
  output logic  idle,
  output logic  out_load,
  output ctrl_t ctrl
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_G0, S_G1, S_G2,
    S_P0, S_P1, S_P2, S_P3, S_P4,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_B8,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   ch_r, ch_nxt;
  logic   lo_r, lo_nxt;
  logic   more;

  // Second channel still to run after the current one.
  assign more     = !ch_r && !lo_r;
  assign idle     = (state_r == S_IDLE);
  assign out_load = (state_r == S_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    lo_nxt    = lo_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ch_nxt = 1'b0;
          lo_nxt = left_only;
          case (kind)
            KIND_GAIN:   state_nxt = S_G0;
            KIND_POLE:   state_nxt = S_P0;
            KIND_BIQUAD: state_nxt = S_B0;
            default:     state_nxt = S_FIN;
          endcase
        end
      end
      S_G0: state_nxt = S_G1;
      S_G1: state_nxt = S_G2;
      S_G2: begin
        ch_nxt    = more ? 1'b1 : ch_r;
        state_nxt = more ? S_G0 : S_FIN;
      end
      S_P0: state_nxt = S_P1;
      S_P1: state_nxt = S_P2;
      S_P2: state_nxt = S_P3;
      S_P3: state_nxt = S_P4;
      S_P4: begin
        ch_nxt    = more ? 1'b1 : ch_r;
        state_nxt = more ? S_P0 : S_FIN;
      end
      S_B0: state_nxt = S_B1;
      S_B1: state_nxt = S_B2;
      S_B2: state_nxt = S_B3;
      S_B3: state_nxt = S_B4;
      S_B4: state_nxt = S_B5;
      S_B5: state_nxt = S_B6;
      S_B6: state_nxt = S_B7;
      S_B7: state_nxt = S_B8;
      S_B8: begin
        ch_nxt    = more ? 1'b1 : ch_r;
        state_nxt = more ? S_B0 : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Step decode. A product issued in one step is accumulated in the next.
  always_comb begin
    ctrl.mul_en   = 1'b0;
    ctrl.coef_sel = COEF_GAIN;
    ctrl.opb_sel  = OPB_X;
    ctrl.acc_op   = ACC_HOLD;
    ctrl.bias_sel = BIAS_BQ;
    ctrl.wb_op    = WB_NONE;
    ctrl.ch       = ch_r;
    case (state_r)
      S_G0: begin
        ctrl.mul_en   = 1'b1;
        ctrl.coef_sel = COEF_GAIN;
      end
      S_G1: begin
        ctrl.acc_op   = ACC_LOAD;
        ctrl.bias_sel = BIAS_GAIN;
      end
      S_G2: ctrl.wb_op = WB_GAIN_OUT;
      S_P0: ctrl.wb_op = WB_POLE_DIFF;
      S_P1: begin
        ctrl.mul_en   = 1'b1;
        ctrl.coef_sel = COEF_POLE;
        ctrl.opb_sel  = OPB_DIFF;
      end
      S_P2: begin
        ctrl.acc_op   = ACC_LOAD;
        ctrl.bias_sel = BIAS_POLE;
      end
      S_P3: ctrl.wb_op = WB_POLE_STATE;
      S_P4: ctrl.wb_op = WB_POLE_OUT;
      S_B0: begin
        ctrl.mul_en   = 1'b1;
        ctrl.coef_sel = COEF_B0;
      end
      S_B1: begin
        ctrl.acc_op   = ACC_LOAD;
        ctrl.bias_sel = BIAS_BQ_Y;
        ctrl.mul_en   = 1'b1;
        ctrl.coef_sel = COEF_B1;
      end
      S_B2: begin
        ctrl.wb_op    = WB_BQ_Y;
        ctrl.acc_op   = ACC_LOAD;
        ctrl.bias_sel = BIAS_BQ;
      end
      S_B3: ctrl.wb_op = WB_BQ_YS;
      S_B4: begin
        ctrl.mul_en   = 1'b1;
        ctrl.coef_sel = COEF_A1;
        ctrl.opb_sel  = OPB_YS;
      end
      S_B5: begin
        ctrl.acc_op   = ACC_SUB;
        ctrl.mul_en   = 1'b1;
        ctrl.coef_sel = COEF_B2;
      end
      S_B6: begin
        ctrl.wb_op    = WB_BQ_Z1;
        ctrl.acc_op   = ACC_LOAD;
        ctrl.bias_sel = BIAS_BQ;
        ctrl.mul_en   = 1'b1;
        ctrl.coef_sel = COEF_A2;
        ctrl.opb_sel  = OPB_YS;
      end
      S_B7: ctrl.acc_op = ACC_SUB;
      S_B8: ctrl.wb_op  = WB_BQ_Z2;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= 1'b0;
      lo_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      lo_r    <= lo_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/stereo_gain_onepole_biquad_stage.sv]
// Top level of the stereo gain / one-pole / biquad effect stage.
//
//  channel   | dir | handshake    | request payload
//  ----------+-----+--------------+--------------------------------------------
//  in_chan   | in  | valid/ready  | sample_left, sample_right, left_only
//  out_chan  | out | valid/ready  | out_left, out_right (saturated Q1.23)
//  cfg_chan  | in  | valid/ready  | index (register number), data
//
// Gain, one-pole and biquad frames run the effect's per-channel steps for the
//   left channel, then the right; with left_only set the per-channel part
//   (3, 5 or 9 steps) runs once instead of twice. Bypass runs no steps.
// The steps are set by the single shared multiplier and accumulator, which
// every product of the frame passes through one after another.
// rst_n is synchronous, active low; it resets control, config and the delays.
// A finished frame sits in the output register; a stalled out_chan holds the
// sequencer in its final step, and in_chan ready is low until it moves on.
`default_nettype none

module stereo_gain_onepole_biquad_stage import sgob_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sgob_in_if.sink    in_chan,
  sgob_out_if.source out_chan,
  sgob_cfg_if.sink   cfg_chan
);

  localparam int SB      = SAMPLE_BITS;
  localparam int POLE_W  = SB + POLE_GUARD;       // one-pole state range, Q1.31
  localparam int OPB_W   = POLE_W + 1;            // holds x, ys and y - x
  localparam int PROD_W  = COEF_BITS + OPB_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int WB_W    = ((ACC_W > STATE_BITS) ? ACC_W : STATE_BITS) + 2;
  localparam int GAIN_SH = COEF_BITS - GAIN_INT_BITS;
  localparam int POLE_SH = COEF_BITS - POLE_INT_BITS;
  localparam int BQ_SH   = COEF_BITS - BQ_INT_BITS - BQ_GUARD;
  localparam logic signed [WB_W-1:0] POLE_HALF = WB_W'(1) <<< (POLE_GUARD - 1);

  // Clamp a wide value to the signed range of w bits.
  function automatic logic signed [WB_W-1:0] sat_to(
    input logic signed [WB_W-1:0] v,
    input int                     w
  );
    logic signed [WB_W-1:0] hi;
    logic signed [WB_W-1:0] lo;
    hi = (WB_W'(1) <<< (w - 1)) - WB_W'(1);
    lo = -hi - WB_W'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  ctrl_t                       ctrl;
  kind_t                       kind;
  logic signed [COEF_BITS-1:0] coef;
  logic signed [ACC_W-1:0]     acc;
  logic signed [OPB_W-1:0]     opb;
  logic                        seq_idle;
  logic                        out_load;
  logic                        out_free;
  logic                        accept;

  // Frame registers and per-channel delays (z1 / one-pole y, z2).
  logic signed [SB-1:0]         xl_r, xr_r, yl_r, yr_r;
  logic signed [SB-1:0]         yl_nxt, yr_nxt;
  logic signed [SB-1:0]         ys_r, ys_nxt;
  logic signed [OPB_W-1:0]      d_r, d_nxt;
  logic signed [WB_W-1:0]       t_r, t_nxt;
  logic signed [STATE_BITS-1:0] fd_r [2];
  logic signed [STATE_BITS-1:0] sd_r [2];
  logic signed [STATE_BITS-1:0] fd_nxt [2];
  logic signed [STATE_BITS-1:0] sd_nxt [2];
  logic signed [SB-1:0]         out_left_r, out_right_r;
  logic                         out_valid_r, out_valid_nxt;

  // Writeback operands; the wide ones share the common width.
  logic signed [SB-1:0]   x_cur;
  logic signed [WB_W-1:0] acc_w, fd_w, sd_w, x8_w;
  logic signed [SB-1:0]   y_val;
  logic                   y_we;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = seq_idle;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_left  = out_left_r;
  assign out_chan.out_right = out_right_r;

  sgob_cfg #(
    .COEF_BITS (COEF_BITS)
  ) u_sgob_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .coef_sel (ctrl.coef_sel),
    .kind     (kind),
    .coef     (coef)
  );

  sgob_seq u_sgob_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .kind      (kind),
    .left_only (in_chan.left_only),
    .out_free  (out_free),
    .idle      (seq_idle),
    .out_load  (out_load),
    .ctrl      (ctrl)
  );

  sgob_mac #(
    .COEF_BITS (COEF_BITS),
    .OPB_W     (OPB_W),
    .ACC_W     (ACC_W)
  ) u_sgob_mac (
    .clk  (clk),
    .ctrl (ctrl),
    .coef (coef),
    .opb  (opb),
    .acc  (acc)
  );

  assign x_cur = ctrl.ch ? xr_r : xl_r;

  always_comb begin
    case (ctrl.opb_sel)
      OPB_YS:   opb = OPB_W'(ys_r);
      OPB_DIFF: opb = d_r;
      default:  opb = OPB_W'(x_cur);
    endcase
  end

  assign acc_w = WB_W'(acc);
  assign fd_w  = WB_W'(fd_r[ctrl.ch]);
  assign sd_w  = WB_W'(sd_r[ctrl.ch]);
  assign x8_w  = WB_W'(x_cur) <<< POLE_GUARD;

  // Writeback: one add and one clamp per step at most.
  always_comb begin
    d_nxt  = d_r;
    t_nxt  = t_r;
    ys_nxt = ys_r;
    fd_nxt = fd_r;
    sd_nxt = sd_r;
    y_val  = ys_r;
    y_we   = 1'b0;
    case (ctrl.wb_op)
      WB_GAIN_OUT: begin
        y_val = SB'(sat_to(acc_w >>> GAIN_SH, SB));
        y_we  = 1'b1;
      end
      WB_POLE_DIFF: begin
        // stored y may come from the biquad; clamp to the one-pole range
        d_nxt = OPB_W'(sat_to(fd_w, POLE_W) - x8_w);
      end
      WB_POLE_STATE: begin
        fd_nxt[ctrl.ch] = STATE_BITS'(sat_to(x8_w + (acc_w >>> POLE_SH), POLE_W));
      end
      WB_POLE_OUT: begin
        y_val = SB'(sat_to((fd_w + POLE_HALF) >>> POLE_GUARD, SB));
        y_we  = 1'b1;
      end
      WB_BQ_Y: begin
        // acc already carries the guard rounding offset
        t_nxt = (acc_w >>> BQ_SH) + fd_w;
      end
      WB_BQ_YS: begin
        ys_nxt = SB'(sat_to(t_r >>> BQ_GUARD, SB));
        y_val  = ys_nxt;
        y_we   = 1'b1;
      end
      WB_BQ_Z1: begin
        fd_nxt[ctrl.ch] = STATE_BITS'(sat_to((acc_w >>> BQ_SH) + sd_w, STATE_BITS));
      end
      WB_BQ_Z2: begin
        sd_nxt[ctrl.ch] = STATE_BITS'(sat_to(acc_w >>> BQ_SH, STATE_BITS));
      end
      default: ;
    endcase
  end

  // Results start as the inputs: covers bypass and a passed-through right.
  always_comb begin
    yl_nxt = yl_r;
    yr_nxt = yr_r;
    if (accept) begin
      yl_nxt = in_chan.sample_left;
      yr_nxt = in_chan.sample_right;
    end else if (y_we) begin
      if (ctrl.ch) begin
        yr_nxt = y_val;
      end else begin
        yl_nxt = y_val;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      xl_r <= in_chan.sample_left;
      xr_r <= in_chan.sample_right;
    end
    yl_r <= yl_nxt;
    yr_r <= yr_nxt;
    ys_r <= ys_nxt;
    d_r  <= d_nxt;
    t_r  <= t_nxt;
    if (out_load) begin
      out_left_r  <= yl_r;
      out_right_r <= yr_r;
    end
  end

  // Filter state and output flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r[0]     <= '0;
      fd_r[1]     <= '0;
      sd_r[0]     <= '0;
      sd_r[1]     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fd_r        <= fd_nxt;
      sd_r        <= sd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/sgob_checker.sv]
// Port-level checker of the stereo effect stage and its bind.
`default_nettype none
`include "stereo_gain_onepole_biquad_stage_defines.svh"

module sgob_checker import sgob_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_left,
  input logic [SAMPLE_BITS-1:0] out_right
);

  `SGOB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left) && $stable(out_right), "stalled result request changed or dropped")

  `SGOB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input ready stayed high after an accepted request")

  `SGOB_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(!in_ready), "result appeared while the block was idle")

endmodule

bind stereo_gain_onepole_biquad_stage sgob_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sgob_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_left  (out_chan.out_left),
  .out_right (out_chan.out_right)
);

`default_nettype wire
